// ===== design/bpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bpt_pkg: shared types and constants of the branch predictor trainer
// Field widths, the classified branch record, the table entry layout and
// the back-end state encoding.
// ----------------------------------------------------------------------------
package bpt_pkg;

  localparam int PC_W        = 32;
  localparam int OFF_W       = 13;
  localparam int CNT_W       = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Two-bit predictor encodings
  localparam logic [1:0] TB_STRONG_NT = 2'd0;
  localparam logic [1:0] TB_WEAK_NT   = 2'd1;
  localparam logic [1:0] TB_WEAK_T    = 2'd2;
  localparam logic [1:0] TB_STRONG_T  = 2'd3;

  // Classified branch, passed from the front end to the back end
  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic            taken;
    logic [PC_W-1:0] target;
  } item_t;

  // One row of the predictor table
  typedef struct packed {
    logic            valid;
    logic [PC_W-1:0] tag;
    logic            last;
    logic [1:0]      two;
    logic [PC_W-1:0] target;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } back_state_t;

  // A weak state that mispredicts jumps to the opposite strong state
  function automatic logic [1:0] two_bit_next(input logic [1:0] s, input logic tk);
    logic [1:0] r;
    if (tk) begin
      r = (s == TB_STRONG_NT) ? TB_WEAK_NT : TB_STRONG_T;
    end else begin
      r = (s == TB_STRONG_T) ? TB_WEAK_T : TB_STRONG_NT;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

// ===== design/bpt_ram.sv =====
// ----------------------------------------------------------------------------
// bpt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bpt_front.sv =====
// ----------------------------------------------------------------------------
// bpt_front: input stage and branch classifier
// Registers the command beat, decides taken and the target, pushes the
// classified branch into the queue.
// ----------------------------------------------------------------------------
module bpt_front
  import bpt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [PC_W-1:0]         in_branch_pc,
  input  logic signed [OFF_W-1:0] in_branch_offset,
  input  logic [PC_W-1:0]         in_next_pc,
  input  logic                    clearing,
  input  logic                    q_full,
  output logic                    busy,
  output logic                    push,
  output item_t                   push_item
);

  logic                    valid_r, valid_nxt;
  logic [PC_W-1:0]         pc_r;
  logic signed [OFF_W-1:0] off_r;
  logic [PC_W-1:0]         npc_r;
  logic [PC_W-1:0]         off_ext;
  logic                    accept;

  assign busy   = clearing | (valid_r & q_full);
  assign accept = start & ~busy;
  assign push   = valid_r & ~q_full;

  assign off_ext = {{(PC_W-OFF_W){off_r[OFF_W-1]}}, off_r};

  always_comb begin
    push_item.pc     = pc_r;
    push_item.target = pc_r + off_ext;
    push_item.taken  = ((npc_r - pc_r) == off_ext);
  end

  assign valid_nxt = accept | (valid_r & ~push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload: load on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      pc_r  <= in_branch_pc;
      off_r <= in_branch_offset;
      npc_r <= in_next_pc;
    end
  end

endmodule

// ===== design/bpt_queue.sv =====
// ----------------------------------------------------------------------------
// bpt_queue: short queue of classified branches
// Decouples the front end from the table update.
// ----------------------------------------------------------------------------
module bpt_queue
  import bpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

  item_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_QW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/bpt_back.sv =====
// ----------------------------------------------------------------------------
// bpt_back: table update and scoring
// Clears the table after reset, then per branch reads its entry, scores the
// predictors, writes the entry back and presents the result beat.
// ----------------------------------------------------------------------------
module bpt_back
  import bpt_pkg::*;
#(
  parameter int IDX_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             clearing,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output entry_t           ram_wdata,
  output logic             ram_re,
  output logic [IDX_W-1:0] ram_raddr,
  input  entry_t           ram_rdata,
  output logic             out_valid,
  output logic             out_taken,
  output logic [PC_W-1:0]  out_target,
  output logic             out_table_hit,
  output logic             out_one_bit_guess,
  output logic             out_two_bit_guess,
  output logic [CNT_W-1:0] out_total_count,
  output logic [CNT_W-1:0] out_right_always_taken,
  output logic [CNT_W-1:0] out_right_never_taken,
  output logic [CNT_W-1:0] out_right_one_bit,
  output logic [CNT_W-1:0] out_right_two_bit
);

  localparam logic [IDX_W-1:0] LAST_IDX = '1;

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  item_t            item_r;

  logic             hit;
  logic             g1;
  logic [1:0]       s2;
  logic             update;
  entry_t           new_entry;

  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] at_r, at_nxt;
  logic [CNT_W-1:0] nt_r, nt_nxt;
  logic [CNT_W-1:0] one_r, one_nxt;
  logic [CNT_W-1:0] two_r, two_nxt;

  logic             valid_r;
  logic             taken_r, hit_r, g1_r, g2_r;
  logic [PC_W-1:0]  target_r;

  // Lookup: a miss reads as a fresh entry in the not-taken states
  assign hit = ram_rdata.valid & (ram_rdata.tag == item_r.pc);
  assign g1  = hit & ram_rdata.last;
  assign s2  = hit ? ram_rdata.two : TB_STRONG_NT;

  always_comb begin
    new_entry.valid  = 1'b1;
    new_entry.tag    = item_r.pc;
    new_entry.last   = item_r.taken;
    new_entry.two    = two_bit_next(s2, item_r.taken);
    new_entry.target = item_r.target;
  end

  // Next state
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    clearing  = 1'b0;
    q_pop     = 1'b0;
    update    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_idx_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = q_item.pc[IDX_W-1:0];
    case (state_r)
      ST_CLEAR: begin
        clearing = 1'b1;
        ram_we   = 1'b1;
      end
      ST_IDLE: begin
        q_pop  = q_valid;
        ram_re = q_valid;
      end
      ST_UPDATE: begin
        update    = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = item_r.pc[IDX_W-1:0];
        ram_wdata = new_entry;
      end
      default: begin
        clearing = 1'b1;
      end
    endcase
  end

  always_comb begin
    total_nxt = total_r;
    at_nxt    = at_r;
    nt_nxt    = nt_r;
    one_nxt   = one_r;
    two_nxt   = two_r;
    if (update) begin
      total_nxt = sat_inc(total_r);
      if (item_r.taken) begin
        at_nxt = sat_inc(at_r);
      end else begin
        nt_nxt = sat_inc(nt_r);
      end
      if (g1 == item_r.taken) begin
        one_nxt = sat_inc(one_r);
      end
      if (s2[1] == item_r.taken) begin
        two_nxt = sat_inc(two_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
      valid_r   <= 1'b0;
      total_r   <= '0;
      at_r      <= '0;
      nt_r      <= '0;
      one_r     <= '0;
      two_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      valid_r   <= update;
      total_r   <= total_nxt;
      at_r      <= at_nxt;
      nt_r      <= nt_nxt;
      one_r     <= one_nxt;
      two_r     <= two_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (update) begin
      taken_r  <= item_r.taken;
      target_r <= item_r.target;
      hit_r    <= hit;
      g1_r     <= g1;
      g2_r     <= s2[1];
    end
  end

  assign out_valid              = valid_r;
  assign out_taken              = taken_r;
  assign out_target             = target_r;
  assign out_table_hit          = hit_r;
  assign out_one_bit_guess      = g1_r;
  assign out_two_bit_guess      = g2_r;
  assign out_total_count        = total_r;
  assign out_right_always_taken = at_r;
  assign out_right_never_taken  = nt_r;
  assign out_right_one_bit      = one_r;
  assign out_right_two_bit      = two_r;

endmodule

// ===== design/branch_predictor_trainer_top.sv =====
// ----------------------------------------------------------------------------
// branch_predictor_trainer_top: bimodal 1-bit / 2-bit predictor trainer
// Scores resolved branches against four prediction schemes and keeps a
// direct-mapped predictor table with a branch target buffer.
// ----------------------------------------------------------------------------
// A branch beat is taken when start is high and busy is low. Each accepted
// beat yields exactly one result beat, shown for one cycle with out_valid
// high; the receiver cannot stall, so results are never held back. After
// reset the table is swept clear, one entry per cycle; busy stays high
// during the sweep. After that the table update reads the entry when the
// branch is popped, then scores it and writes the entry back, and the back
// end takes no new branch until that write is done. When idle, a branch
// passes the input register (loaded at the accepting edge), the queue,
// the table read and the result register on its way to out_valid.
// The front end and a two-entry queue absorb short bursts; outside the
// sweep, busy rises only when the queue and the input register are both
// full. TABLE_ENTRIES must be a power of two; the table index is the
// low bits of the branch pc and the tag is the full pc.
// ----------------------------------------------------------------------------
module branch_predictor_trainer_top
  import bpt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [PC_W-1:0]         in_branch_pc,
  input  logic signed [OFF_W-1:0] in_branch_offset,
  input  logic [PC_W-1:0]         in_next_pc,
  output logic                    out_valid,
  output logic                    out_taken,
  output logic [PC_W-1:0]         out_target,
  output logic                    out_table_hit,
  output logic                    out_one_bit_guess,
  output logic                    out_two_bit_guess,
  output logic [CNT_W-1:0]        out_total_count,
  output logic [CNT_W-1:0]        out_right_always_taken,
  output logic [CNT_W-1:0]        out_right_never_taken,
  output logic [CNT_W-1:0]        out_right_one_bit,
  output logic [CNT_W-1:0]        out_right_two_bit
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int ENTRY_W = $bits(entry_t);

  // Front end to queue
  logic             push;
  item_t            push_item;
  logic             q_full;

  // Queue to back end
  logic             q_pop;
  logic             q_valid;
  item_t            q_item;

  // Table port
  logic             clearing;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  // Accept the beat and classify taken / target
  bpt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_branch_pc     (in_branch_pc),
    .in_branch_offset (in_branch_offset),
    .in_next_pc       (in_next_pc),
    .clearing         (clearing),
    .q_full           (q_full),
    .busy             (busy),
    .push             (push),
    .push_item        (push_item)
  );

  // Hold classified branches until the table is free
  bpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  // Read-modify-write the table entry and score the predictors
  bpt_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_valid),
    .q_item                 (q_item),
    .q_pop                  (q_pop),
    .clearing               (clearing),
    .ram_we                 (ram_we),
    .ram_waddr              (ram_waddr),
    .ram_wdata              (ram_wdata),
    .ram_re                 (ram_re),
    .ram_raddr              (ram_raddr),
    .ram_rdata              (ram_rdata),
    .out_valid              (out_valid),
    .out_taken              (out_taken),
    .out_target             (out_target),
    .out_table_hit          (out_table_hit),
    .out_one_bit_guess      (out_one_bit_guess),
    .out_two_bit_guess      (out_two_bit_guess),
    .out_total_count        (out_total_count),
    .out_right_always_taken (out_right_always_taken),
    .out_right_never_taken  (out_right_never_taken),
    .out_right_one_bit      (out_right_one_bit),
    .out_right_two_bit      (out_right_two_bit)
  );

  // Predictor table: valid, tag, 1-bit, 2-bit and target per entry
  bpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
